// File: rtl/fla_pkg.sv
// shared types, constants and helpers for the frame loss accounting blocker
package fla_pkg;

  localparam int FRAME_W  = 48;
  localparam int EV_W     = 14;
  localparam int CAP_W    = 17;
  localparam int SEQ_W    = 32;
  localparam int REL_W    = 33;
  localparam int IN_DW    = 64;
  localparam int OUT_DW   = 376;

  localparam int MAX_FRAME_EVENTS = 8192;
  localparam logic [CAP_W-1:0]   CAP_RESET  = 17'd2048;
  localparam logic [CAP_W-1:0]   CAP_MAX    = 17'h10000;
  localparam logic [FRAME_W-1:0] SPAN_LIMIT = 48'h0001_0000_0000;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // input item after the front stage
  typedef struct packed {
    logic               cmd;
    logic [FRAME_W-1:0] frame;
    logic               lost;
    logic [EV_W-1:0]    n;
    logic               order_err;
    logic [FRAME_W-1:0] inc_total;
    logic [FRAME_W-1:0] inc_lost_all;
  } front_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] total;
    logic [FRAME_W-1:0] lost_all;
    logic [FRAME_W-1:0] lost_some;
    logic [FRAME_W-1:0] ev_clean;
    logic [FRAME_W-1:0] ev_lossy;
  } tally_t;

  typedef struct packed {
    logic               closed;
    logic [CAP_W-1:0]   closed_fill;
    logic [SEQ_W-1:0]   seq;
    logic [FRAME_W-1:0] base;
    logic [REL_W-1:0]   rel;
  } block_res_t;

  function automatic logic [FRAME_W-1:0] sat_add(input logic [FRAME_W-1:0] a,
                                                 input logic [FRAME_W-1:0] b);
    logic [FRAME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FRAME_W] ? {FRAME_W{1'b1}} : s[FRAME_W-1:0];
  endfunction

endpackage

// File: rtl/fla_front.sv
// front stage: input register, event clamp and frame gap arithmetic
module fla_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic                          in_cmd,
  input  logic [fla_pkg::FRAME_W-1:0]   in_frame,
  input  logic                          in_lost,
  input  logic [fla_pkg::EV_W-1:0]      in_n,
  output fla_pkg::front_item_t          item_r
);
  import fla_pkg::*;

  logic [FRAME_W-1:0] prev_r;
  logic               seen_r;
  logic               prev_lost_all_r;
  front_item_t        item_nxt;
  logic [EV_W-1:0]    n_cl;
  logic               gt;
  logic               lost_empty;

  always_comb begin
    n_cl       = (in_n > EV_W'(MAX_FRAME_EVENTS)) ? EV_W'(MAX_FRAME_EVENTS) : in_n;
    gt         = seen_r && (in_frame > prev_r);
    lost_empty = in_lost && (n_cl == '0);
    item_nxt.cmd       = in_cmd;
    item_nxt.frame     = in_frame;
    item_nxt.lost      = in_lost;
    item_nxt.n         = n_cl;
    item_nxt.order_err = seen_r && !gt;
    // skipped numbers plus this frame
    item_nxt.inc_total = gt ? (in_frame - prev_r) : FRAME_W'(1);
    // frame + ~prev + x equals frame - prev - 1 + x
    item_nxt.inc_lost_all = (gt && prev_lost_all_r) ?
                            (in_frame + ~prev_r + FRAME_W'(lost_empty)) :
                            FRAME_W'(lost_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r          <= '0;
      seen_r          <= 1'b0;
      prev_lost_all_r <= 1'b0;
    end else if (acc && in_cmd == CMD_FRAME) begin
      prev_r          <= in_frame;
      seen_r          <= 1'b1;
      prev_lost_all_r <= lost_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: rtl/fla_tally.sv
// saturating frame and event tallies
module fla_tally (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  fla_pkg::front_item_t item,
  output fla_pkg::tally_t      tally_nxt
);
  import fla_pkg::*;

  tally_t tally_r;

  always_comb begin
    tally_nxt = tally_r;
    if (item.cmd == CMD_FRAME) begin
      tally_nxt.total    = sat_add(tally_r.total, item.inc_total);
      tally_nxt.lost_all = sat_add(tally_r.lost_all, item.inc_lost_all);
      tally_nxt.lost_some = sat_add(tally_r.lost_some,
                                    FRAME_W'(item.lost && item.n != '0));
      if (item.lost) begin
        tally_nxt.ev_lossy = sat_add(tally_r.ev_lossy, FRAME_W'(item.n));
      end else begin
        tally_nxt.ev_clean = sat_add(tally_r.ev_clean, FRAME_W'(item.n));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (en) begin
      tally_r <= tally_nxt;
    end
  end

endmodule

// File: rtl/fla_block.sv
// event block packing: open, fill, close on room, span or flush
module fla_block (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  fla_pkg::front_item_t        item,
  input  logic [fla_pkg::CAP_W-1:0]   min_cap,
  output fla_pkg::block_res_t         res
);
  import fla_pkg::*;

  logic               open_r, open_nxt;
  logic [FRAME_W-1:0] start_r, start_nxt;
  logic [CAP_W-1:0]   fill_r, fill_nxt;
  logic [CAP_W-1:0]   room_r, room_nxt;
  logic [SEQ_W-1:0]   cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] span;
  logic               too_far;
  logic               short_room;
  logic [CAP_W-1:0]   n17;
  logic [CAP_W-1:0]   cap_lim;
  logic [CAP_W-1:0]   cap;

  always_comb begin
    n17        = CAP_W'(item.n);
    span       = item.frame - start_r;
    too_far    = (item.frame >= start_r) && (span > SPAN_LIMIT);
    short_room = room_r < n17;
    cap_lim    = min_cap[CAP_W-1] ? CAP_MAX : min_cap;
    cap        = (cap_lim < n17) ? n17 : cap_lim;

    open_nxt        = open_r;
    start_nxt       = start_r;
    fill_nxt        = fill_r;
    room_nxt        = room_r;
    cnt_nxt         = cnt_r;
    res.closed      = 1'b0;
    res.closed_fill = '0;
    res.rel         = '0;

    if (item.cmd == CMD_FLUSH) begin
      if (open_r) begin
        res.closed      = 1'b1;
        res.closed_fill = fill_r;
        open_nxt        = 1'b0;
        start_nxt       = '0;
        fill_nxt        = '0;
        room_nxt        = '0;
      end
    end else if (item.n != '0) begin
      if (!open_r || short_room || too_far) begin
        // close the old block when there is one, then open a fresh one here
        if (open_r) begin
          res.closed      = 1'b1;
          res.closed_fill = fill_r;
        end
        open_nxt  = 1'b1;
        start_nxt = item.frame;
        fill_nxt  = n17;
        room_nxt  = cap - n17;
        cnt_nxt   = cnt_r + SEQ_W'(1);
      end else begin
        res.rel  = span[REL_W-1:0];
        fill_nxt = fill_r + n17;
        room_nxt = room_r - n17;
      end
    end

    res.seq  = open_nxt ? (cnt_nxt - SEQ_W'(1)) : '0;
    res.base = open_nxt ? start_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      fill_r  <= '0;
      room_r  <= '0;
      cnt_r   <= '0;
    end else if (en) begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
      fill_r  <= fill_nxt;
      room_r  <= room_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/frame_loss_accounting_blocker_core.sv
// top level of the frame loss accounting blocker
// Takes one decoded frame header item (or a flush command) per cycle and returns one
// result item per input item, in order. Throughput is one item per clock unless the
// receiver holds out_tready low: an item is registered in the front stage, where the
// gap to the previous frame number is worked out, then the tallies and block packer
// update and the result is registered in the output register. The output register
// and the front stage form a two-deep pipeline, so a new item is taken while a
// finished result still waits for out_tready, provided the front stage is empty.
// All tallies saturate at 2^48-1.
// min_block_capacity may be written through cfg_we/cfg_wdata only while the block is
// idle; values above 65536 act as 65536 and zero lets the frame's event count decide.
module frame_loss_accounting_blocker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // config: min_block_capacity
  input  logic                         cfg_we,
  input  logic [fla_pkg::CAP_W-1:0]    cfg_wdata,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // frame_number[47:0], frame_lost[48], event_count[62:49], zero pad[63]
  input  logic [fla_pkg::IN_DW-1:0]    in_tdata,
  // cmd
  input  logic                         in_tuser,
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // total_frames[47:0], frames_lost_all[95:48], frames_lost_some[143:96],
  // events_clean[191:144], events_lossy[239:192], block_closed[240],
  // closed_block_fill[257:241], block_sequence[289:258],
  // block_base_frame[337:290], relative_frame[370:338], order_error[371],
  // zero pad[375:372]
  output logic [fla_pkg::OUT_DW-1:0]   out_tdata
);
  import fla_pkg::*;

  logic             cap_r;
  logic [CAP_W-1:0] min_cap_r;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic             in_acc;
  logic             adv;
  front_item_t      item;
  tally_t           tally_nxt;
  block_res_t       blk;
  logic [OUT_DW-1:0] out_data_r;
  logic [OUT_DW-1:0] out_data_nxt;

  // front stage moves forward whenever the output register is empty or draining
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cap_r     = cfg_we;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cap_r <= CAP_RESET;
    end else if (cap_r) begin
      min_cap_r <= cfg_wdata;
    end
  end

  fla_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .in_cmd   (in_tuser),
    .in_frame (in_tdata[47:0]),
    .in_lost  (in_tdata[48]),
    .in_n     (in_tdata[62:49]),
    .item_r   (item)
  );

  fla_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .item      (item),
    .tally_nxt (tally_nxt)
  );

  fla_block u_block (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .item    (item),
    .min_cap (min_cap_r),
    .res     (blk)
  );

  // pack the result item, highest field first
  assign out_data_nxt = {4'b0000,
                         (item.cmd == CMD_FRAME) && item.order_err,
                         blk.rel, blk.base, blk.seq, blk.closed_fill, blk.closed,
                         tally_nxt.ev_lossy, tally_nxt.ev_clean,
                         tally_nxt.lost_some, tally_nxt.lost_all, tally_nxt.total};

  // valid flags for the two pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // input is held off only while both stages are full
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  // no fill is reported unless a block was handed off
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[240]) |-> (out_data_r[257:241] == '0))
    else $error("closed block fill without a closed block");

  // every frame item adds at least one to the total frame tally until it saturates
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.cmd == CMD_FRAME) |-> (tally_nxt.total != '0))
    else $error("frame item left the total frame tally at zero");

endmodule

// File: tb/tb.sv
// self-checking testbench for frame_loss_accounting_blocker_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fla_pkg::*;

  // one result item as laid out on out_tdata, highest field first
  typedef struct packed {
    logic [3:0]         pad;
    logic               order_error;
    logic [REL_W-1:0]   relative_frame;
    logic [FRAME_W-1:0] block_base_frame;
    logic [SEQ_W-1:0]   block_sequence;
    logic [CAP_W-1:0]   closed_block_fill;
    logic               block_closed;
    logic [FRAME_W-1:0] events_lossy;
    logic [FRAME_W-1:0] events_clean;
    logic [FRAME_W-1:0] frames_lost_some;
    logic [FRAME_W-1:0] frames_lost_all;
    logic [FRAME_W-1:0] total_frames;
  } frame_report_t;

  localparam logic [EV_W-1:0]    EVENT_CLAMP = EV_W'(MAX_FRAME_EVENTS);
  localparam logic [FRAME_W-1:0] FRAME_TOP   = {FRAME_W{1'b1}};
  localparam int                 HOLD_CYCLES = 400;

  // dut ports; the inputs are at known values from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;

  frame_loss_accounting_blocker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // accounting predictor: own copy of the tallies, the packer and the register
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0]   min_capacity = CAP_RESET;
  logic [FRAME_W-1:0] prev_frame = '0;
  logic               seen_frame = 1'b0;
  logic               prev_lost_all = 1'b0;
  logic [FRAME_W-1:0] tally_total = '0;
  logic [FRAME_W-1:0] tally_lost_all = '0;
  logic [FRAME_W-1:0] tally_lost_some = '0;
  logic [FRAME_W-1:0] tally_ev_clean = '0;
  logic [FRAME_W-1:0] tally_ev_lossy = '0;
  logic               blk_open = 1'b0;
  logic [FRAME_W-1:0] blk_base = '0;
  logic [CAP_W-1:0]   blk_fill = '0;
  logic [CAP_W-1:0]   blk_room = '0;
  logic [SEQ_W-1:0]   blk_count = '0;

  frame_report_t expected_reports[$];

  function automatic logic [FRAME_W-1:0] saturating_add(input logic [FRAME_W-1:0] a,
                                                        input logic [FRAME_W-1:0] b);
    logic [FRAME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, FRAME_TOP}) ? FRAME_TOP : s[FRAME_W-1:0];
  endfunction

  // new block gets at least the frame's events, register clamped to 65536
  function automatic void open_block(input logic [FRAME_W-1:0] frame,
                                     input logic [EV_W-1:0] n);
    logic [CAP_W-1:0] cap;
    cap = min_capacity;
    if (cap > CAP_MAX) cap = CAP_MAX;
    if (cap < CAP_W'(n)) cap = CAP_W'(n);
    blk_open  = 1'b1;
    blk_base  = frame;
    blk_fill  = '0;
    blk_room  = cap;
    blk_count = blk_count + SEQ_W'(1);
  endfunction

  function automatic frame_report_t account_frame(input logic cmd,
                                                  input logic [FRAME_W-1:0] frame,
                                                  input logic lost,
                                                  input logic [EV_W-1:0] n_raw);
    frame_report_t      r;
    logic [EV_W-1:0]    n;
    logic [FRAME_W-1:0] frame_gap;
    logic               too_far;
    r = '0;
    n = (n_raw > EVENT_CLAMP) ? EVENT_CLAMP : n_raw;
    if (cmd == CMD_FLUSH) begin
      // end of step: hand off the open block, frame fields are don't-care
      if (blk_open) begin
        r.block_closed      = 1'b1;
        r.closed_block_fill = blk_fill;
        blk_open = 1'b0;
        blk_fill = '0;
        blk_room = '0;
        blk_base = '0;
      end
    end else begin
      if (seen_frame) begin
        if (frame <= prev_frame) begin
          r.order_error = 1'b1;
        end else if (frame - prev_frame > 48'd1) begin
          // numbers skipped in the sequence still count as frames
          frame_gap = frame - prev_frame - 48'd1;
          tally_total = saturating_add(tally_total, frame_gap);
          if (prev_lost_all) tally_lost_all = saturating_add(tally_lost_all, frame_gap);
        end
      end
      tally_total = saturating_add(tally_total, 48'd1);
      if (lost && n == 0) tally_lost_all = saturating_add(tally_lost_all, 48'd1);
      if (lost && n != 0) tally_lost_some = saturating_add(tally_lost_some, 48'd1);
      if (lost) tally_ev_lossy = saturating_add(tally_ev_lossy, FRAME_W'(n));
      else tally_ev_clean = saturating_add(tally_ev_clean, FRAME_W'(n));
      prev_lost_all = lost && (n == 0);
      prev_frame    = frame;
      seen_frame    = 1'b1;
      if (n != 0) begin
        if (!blk_open) begin
          open_block(frame, n);
        end else begin
          too_far = (frame >= blk_base) && (frame - blk_base > SPAN_LIMIT);
          if (blk_room < CAP_W'(n) || too_far) begin
            r.block_closed      = 1'b1;
            r.closed_block_fill = blk_fill;
            open_block(frame, n);
          end
        end
        frame_gap = frame - blk_base;
        r.relative_frame = frame_gap[REL_W-1:0];
        blk_fill = blk_fill + CAP_W'(n);
        blk_room = blk_room - CAP_W'(n);
      end
    end
    r.total_frames     = tally_total;
    r.frames_lost_all  = tally_lost_all;
    r.frames_lost_some = tally_lost_some;
    r.events_clean     = tally_ev_clean;
    r.events_lossy     = tally_ev_lossy;
    if (blk_open) begin
      r.block_sequence   = blk_count - SEQ_W'(1);
      r.block_base_frame = blk_base;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  int mismatches = 0;
  int results_seen = 0;

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  // out_tready and out_tvalid are read before this edge's updates land
  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %0h", results_seen, out_tdata);
      end else begin
        want = expected_reports.pop_front();
        check_field("total_frames", 64'(want.total_frames), 64'(got.total_frames));
        check_field("frames_lost_all", 64'(want.frames_lost_all),
                    64'(got.frames_lost_all));
        check_field("frames_lost_some", 64'(want.frames_lost_some),
                    64'(got.frames_lost_some));
        check_field("events_clean", 64'(want.events_clean), 64'(got.events_clean));
        check_field("events_lossy", 64'(want.events_lossy), 64'(got.events_lossy));
        check_field("block_closed", 64'(want.block_closed), 64'(got.block_closed));
        check_field("closed_block_fill", 64'(want.closed_block_fill),
                    64'(got.closed_block_fill));
        check_field("block_sequence", 64'(want.block_sequence),
                    64'(got.block_sequence));
        check_field("block_base_frame", 64'(want.block_base_frame),
                    64'(got.block_base_frame));
        check_field("relative_frame", 64'(want.relative_frame),
                    64'(got.relative_frame));
        check_field("order_error", 64'(want.order_error), 64'(got.order_error));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: rotating stall mask, reloaded when its countdown runs out, and a
  // long hold-off on request that is timed in its own process
  // ---------------------------------------------------------------------------
  event        hold_start;
  logic        hold_off = 1'b0;
  int          mask_left = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  always @(posedge clk) begin
    if (mask_left == 0) begin
      mask_left = $urandom_range(16, 96);
      // a third of the time no stalls at all, else a random pattern
      stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    mask_left--;
    stall_mask = {stall_mask[14:0], stall_mask[15]};
    out_tready <= hold_off ? 1'b0 : stall_mask[0];
  end

  initial begin
    forever begin
      @(hold_start);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, or back to back
  // ---------------------------------------------------------------------------
  int                 burst_left = 0;
  logic               steady_send = 1'b0;
  logic [FRAME_W-1:0] frame_cursor = '0;

  // offer one item, wait for the handshake, then log what it should produce
  task automatic send_item(input logic cmd, input logic [FRAME_W-1:0] frame,
                           input logic lost, input logic [EV_W-1:0] n);
    int gap;
    if (burst_left == 0) begin
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, n, lost, frame};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    expected_reports.push_back(account_frame(cmd, frame, lost, n));
  endtask

  // mostly a well-formed rising frame sequence, with flushes, far jumps
  // (block span), repeats and backward jumps (order errors) mixed in
  task automatic send_random_frame();
    int              pick;
    logic            lost;
    logic [EV_W-1:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_item(CMD_FLUSH, 48'({$urandom, $urandom}), 1'($urandom), 14'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) frame_cursor = frame_cursor + 48'd1;
      else if (pick < 85) frame_cursor = frame_cursor + 48'($urandom_range(2, 12));
      else if (pick < 90)
        frame_cursor = frame_cursor + SPAN_LIMIT - 48'd2 + 48'($urandom_range(0, 4));
      else if (pick < 96) begin
        if (frame_cursor >= 48'd3) frame_cursor = frame_cursor - 48'($urandom_range(0, 3));
      end else frame_cursor = frame_cursor >> $urandom_range(1, 8);
      lost = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) n = '0;
      else if (pick < 80) n = 14'($urandom_range(1, 40));
      else if (pick < 95) n = 14'($urandom_range(41, MAX_FRAME_EVENTS));
      else n = 14'($urandom_range(MAX_FRAME_EVENTS + 1, 16383));
      send_item(CMD_FRAME, frame_cursor, lost, n);
    end
  endtask

  // every item yields one result, so an empty queue means the block is idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_capacity = value;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked frames with the capacity register at its reset value
  task automatic test_directed();
    // flush before any block exists, frame fields all ones
    send_item(CMD_FLUSH, FRAME_TOP, 1'b1, 14'h3FFF);
    // first frame opens block 0, no skipped frames
    send_item(CMD_FRAME, 48'd0, 1'b0, 14'd5);
    // lost and empty
    send_item(CMD_FRAME, 48'd1, 1'b1, 14'd0);
    // three skipped frames after a lost empty one; oversized count clamps and
    // does not fit the room left, so the block is handed off
    send_item(CMD_FRAME, 48'd5, 1'b0, 14'h3FFF);
    // exactly the clamp value into an exhausted block, lost with events
    send_item(CMD_FRAME, 48'd6, 1'b1, EVENT_CLAMP);
    // repeated number: order error, room is zero so another hand-off
    send_item(CMD_FRAME, 48'd6, 1'b0, 14'd1);
    // number below the block base: order error, relative frame wraps
    send_item(CMD_FRAME, 48'd3, 1'b1, 14'd2);
    // span right at the limit stays in the block
    send_item(CMD_FRAME, 48'd6 + SPAN_LIMIT, 1'b0, 14'd1);
    // one past the limit closes by span
    send_item(CMD_FRAME, 48'd7 + SPAN_LIMIT, 1'b0, 14'd1);
    send_item(CMD_FRAME, 48'd8 + SPAN_LIMIT, 1'b1, 14'd0);
    send_item(CMD_FRAME, 48'd9 + SPAN_LIMIT, 1'b0, 14'd0);
    // skip after a clean frame: total only
    send_item(CMD_FRAME, 48'd13 + SPAN_LIMIT, 1'b0, 14'd3);
    // flush an open block, then flush with nothing open
    send_item(CMD_FLUSH, 48'd0, 1'b0, 14'd0);
    send_item(CMD_FLUSH, 48'd0, 1'b0, 14'd0);
  endtask

  // random traffic under a series of capacity settings, extremes included
  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] settings[7];
    settings = '{17'd1, 17'd0, CAP_MAX, 17'h1FFFF, CAP_MAX + 17'd1,
                 17'($urandom_range(2, 4096)), CAP_RESET};
    // start high so the top frame bits get exercised
    frame_cursor = {2'b10, 46'({$urandom, $urandom})};
    foreach (settings[i]) begin
      wait_idle();
      write_capacity(settings[i]);
      repeat (170) send_random_frame();
    end
  endtask

  // receiver holds off while items keep coming back to back
  task automatic test_backpressure();
    -> hold_start;
    steady_send = 1'b1;
    repeat (60) send_random_frame();
    steady_send = 1'b0;
  endtask

  // drive the frame tallies into saturation; runs last since they stay there
  task automatic test_saturation();
    send_item(CMD_FRAME, 48'd1, 1'b1, 14'd0);
    send_item(CMD_FRAME, FRAME_TOP - 48'd1, 1'b1, 14'd0);
    send_item(CMD_FRAME, FRAME_TOP, 1'b0, 14'h3FFF);
    send_item(CMD_FRAME, FRAME_TOP, 1'b1, 14'd7);
    send_item(CMD_FLUSH, FRAME_TOP, 1'b1, 14'h3FFF);
  endtask

  initial begin
    int drain_cycles;
    drain_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity_sweep();
    test_backpressure();
    test_saturation();

    // let the last results drain through the pipeline, plus margin
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_reports.size());
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
